@@ design/aac_pkg.sv @@
// ----------------------------------------------------------------------------
// aac_pkg
// shared types and constants of the annealing acceptance controller
// ----------------------------------------------------------------------------
package aac_pkg;

   // fixed-point format of energies and temperature
   localparam int FRAC_BITS = 16;
   localparam logic [31:0] TEMP_RESET = 32'd1000 << FRAC_BITS;

   // shared restoring divider
   localparam int DIV_W = 48;
   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_W - 1);
   localparam logic [CNT_W-1:0] SCALE_LAST  = CNT_W'(2);
   localparam logic [CNT_W-1:0] SQUARE_LAST = CNT_W'(7);

   // exponential series
   localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
   localparam logic [19:0] DIV6_MUL   = 20'd699051;
   localparam int          DIV6_SHIFT = 22;
   localparam logic [20:0] X_LIMIT    = 21'h10_0000;

   // register reset values
   localparam logic [15:0] INITIAL_SAMPLES_RESET    = 16'd2000;
   localparam logic [19:0] CHAIN_LENGTH_RESET       = 20'd2000;
   localparam logic [15:0] COOLING_FACTOR_RESET     = 16'd60293;
   localparam logic [23:0] START_TEMP_SCALE_RESET   = 24'd94548;
   localparam logic [31:0] MAX_ITERATIONS_RESET     = 32'd1000000;
   localparam logic [31:0] SURFACE_START_ITER_RESET = 32'd500000;

   // register indexes
   localparam logic [2:0] CSR_INITIAL_SAMPLES    = 3'd0;
   localparam logic [2:0] CSR_CHAIN_LENGTH       = 3'd1;
   localparam logic [2:0] CSR_COOLING_FACTOR     = 3'd2;
   localparam logic [2:0] CSR_START_TEMP_SCALE   = 3'd3;
   localparam logic [2:0] CSR_MAX_ITERATIONS     = 3'd4;
   localparam logic [2:0] CSR_SURFACE_START_ITER = 3'd5;

   // decision codes
   localparam logic [1:0] KIND_REJECT   = 2'd0;
   localparam logic [1:0] KIND_DOWNHILL = 2'd1;
   localparam logic [1:0] KIND_UPHILL   = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_DIV_MOD,
      S_COOL,
      S_SAMPLE,
      S_MEAN,
      S_DIV_MEAN,
      S_SCALE,
      S_SET_TEMP,
      S_RATIO,
      S_DIV_RATIO,
      S_POLY1,
      S_POLY2,
      S_POLY3,
      S_POLY4,
      S_SQUARE,
      S_DECIDE,
      S_OUTPUT
   } aac_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MOD_START,
      OP_DIV_STEP,
      OP_COOL,
      OP_SAMPLE,
      OP_MEAN_START,
      OP_SCALE_STEP,
      OP_SET_TEMP,
      OP_RATIO_START,
      OP_Z2,
      OP_Z3,
      OP_Z4,
      OP_POLY,
      OP_SQUARE,
      OP_DECIDE,
      OP_REJECT,
      OP_OUTPUT
   } aac_op_type;

   typedef struct packed {
      logic finished;
      logic positive;
      logic temp_zero;
      logic sample_fill;
      logic div_last;
      logic scale_last;
      logic square_last;
      logic out_free;
   } aac_status_type;

endpackage

@@ design/aac_controller.sv @@
// ----------------------------------------------------------------------------
// aac_controller
// sequencer that steps the datapath through one acceptance decision
// ----------------------------------------------------------------------------
module aac_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  aac_pkg::aac_status_type status,
   output aac_pkg::aac_op_type     op
);

   aac_pkg::aac_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aac_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aac_pkg::S_IDLE:      if (req_valid) state_in = aac_pkg::S_CHECK;
         aac_pkg::S_CHECK:     state_in = status.finished ? aac_pkg::S_OUTPUT
                                                          : aac_pkg::S_DIV_MOD;
         aac_pkg::S_DIV_MOD:   if (status.div_last) state_in = aac_pkg::S_COOL;
         aac_pkg::S_COOL:      state_in = aac_pkg::S_SAMPLE;
         aac_pkg::S_SAMPLE:    state_in = status.sample_fill ? aac_pkg::S_MEAN
                                                             : aac_pkg::S_RATIO;
         aac_pkg::S_MEAN:      state_in = aac_pkg::S_DIV_MEAN;
         aac_pkg::S_DIV_MEAN:  if (status.div_last) state_in = aac_pkg::S_SCALE;
         aac_pkg::S_SCALE:     if (status.scale_last) state_in = aac_pkg::S_SET_TEMP;
         aac_pkg::S_SET_TEMP:  state_in = aac_pkg::S_RATIO;
         aac_pkg::S_RATIO: begin
            if (status.positive && !status.temp_zero) state_in = aac_pkg::S_DIV_RATIO;
            else                                      state_in = aac_pkg::S_DECIDE;
         end
         aac_pkg::S_DIV_RATIO: if (status.div_last) state_in = aac_pkg::S_POLY1;
         aac_pkg::S_POLY1:     state_in = aac_pkg::S_POLY2;
         aac_pkg::S_POLY2:     state_in = aac_pkg::S_POLY3;
         aac_pkg::S_POLY3:     state_in = aac_pkg::S_POLY4;
         aac_pkg::S_POLY4:     state_in = aac_pkg::S_SQUARE;
         aac_pkg::S_SQUARE:    if (status.square_last) state_in = aac_pkg::S_DECIDE;
         aac_pkg::S_DECIDE:    state_in = aac_pkg::S_OUTPUT;
         aac_pkg::S_OUTPUT:    if (status.out_free) state_in = aac_pkg::S_IDLE;
         default:              state_in = aac_pkg::S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      op = aac_pkg::OP_NONE;
      unique case (state_ff)
         aac_pkg::S_IDLE:      if (req_valid) op = aac_pkg::OP_LOAD;
         aac_pkg::S_CHECK:     op = status.finished ? aac_pkg::OP_REJECT
                                                    : aac_pkg::OP_MOD_START;
         aac_pkg::S_DIV_MOD:   op = aac_pkg::OP_DIV_STEP;
         aac_pkg::S_COOL:      op = aac_pkg::OP_COOL;
         aac_pkg::S_SAMPLE:    op = aac_pkg::OP_SAMPLE;
         aac_pkg::S_MEAN:      op = aac_pkg::OP_MEAN_START;
         aac_pkg::S_DIV_MEAN:  op = aac_pkg::OP_DIV_STEP;
         aac_pkg::S_SCALE:     op = aac_pkg::OP_SCALE_STEP;
         aac_pkg::S_SET_TEMP:  op = aac_pkg::OP_SET_TEMP;
         aac_pkg::S_RATIO: begin
            if (status.positive && !status.temp_zero) op = aac_pkg::OP_RATIO_START;
         end
         aac_pkg::S_DIV_RATIO: op = aac_pkg::OP_DIV_STEP;
         aac_pkg::S_POLY1:     op = aac_pkg::OP_Z2;
         aac_pkg::S_POLY2:     op = aac_pkg::OP_Z3;
         aac_pkg::S_POLY3:     op = aac_pkg::OP_Z4;
         aac_pkg::S_POLY4:     op = aac_pkg::OP_POLY;
         aac_pkg::S_SQUARE:    op = aac_pkg::OP_SQUARE;
         aac_pkg::S_DECIDE:    op = aac_pkg::OP_DECIDE;
         aac_pkg::S_OUTPUT:    if (status.out_free) op = aac_pkg::OP_OUTPUT;
         default:              op = aac_pkg::OP_NONE;
      endcase
   end

   assign req_stall = (state_ff != aac_pkg::S_IDLE);

endmodule

@@ design/aac_datapath.sv @@
// ----------------------------------------------------------------------------
// aac_datapath
// annealing state, shared divider, multipliers and the result register
// ----------------------------------------------------------------------------
module aac_datapath #(
   parameter int ITER_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  aac_pkg::aac_op_type     op,
   output aac_pkg::aac_status_type status,
   input  logic                    csr_write_enable,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_data,
   input  logic signed [31:0]      req_energy_change,
   input  logic [15:0]             req_random_uniform,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_accept,
   output logic [1:0]              rsp_accept_kind,
   output logic [31:0]             rsp_current_temp,
   output logic                    rsp_surface_phase,
   output logic                    rsp_finished,
   output logic [31:0]             rsp_downhill_total,
   output logic [31:0]             rsp_uphill_total
);

   localparam int CMP_W = (ITER_WIDTH > 32) ? ITER_WIDTH : 32;
   localparam int DW    = aac_pkg::DIV_W;
   localparam int CW    = aac_pkg::CNT_W;

   // configuration
   logic [15:0] initial_samples_ff;
   logic [19:0] chain_length_ff;
   logic [15:0] cooling_factor_ff;
   logic [23:0] start_temp_scale_ff;
   logic [31:0] max_iterations_ff;
   logic [31:0] surface_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_samples_ff  <= aac_pkg::INITIAL_SAMPLES_RESET;
         chain_length_ff     <= aac_pkg::CHAIN_LENGTH_RESET;
         cooling_factor_ff   <= aac_pkg::COOLING_FACTOR_RESET;
         start_temp_scale_ff <= aac_pkg::START_TEMP_SCALE_RESET;
         max_iterations_ff   <= aac_pkg::MAX_ITERATIONS_RESET;
         surface_start_ff    <= aac_pkg::SURFACE_START_ITER_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            aac_pkg::CSR_INITIAL_SAMPLES:    initial_samples_ff  <= csr_data[15:0];
            aac_pkg::CSR_CHAIN_LENGTH:       chain_length_ff     <= csr_data[19:0];
            aac_pkg::CSR_COOLING_FACTOR:     cooling_factor_ff   <= csr_data[15:0];
            aac_pkg::CSR_START_TEMP_SCALE:   start_temp_scale_ff <= csr_data[23:0];
            aac_pkg::CSR_MAX_ITERATIONS:     max_iterations_ff   <= csr_data;
            aac_pkg::CSR_SURFACE_START_ITER: surface_start_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // annealing state
   logic [ITER_WIDTH-1:0] iteration_ff, iteration_in;
   logic [31:0] temperature_ff, temperature_in;
   logic [15:0] sample_count_ff, sample_count_in;
   logic [47:0] sample_sum_ff, sample_sum_in;
   logic        start_set_ff, start_set_in;
   logic [31:0] downhill_ff, downhill_in;
   logic [31:0] uphill_ff, uphill_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // work registers
   logic [31:0]   raw_ff, raw_in;
   logic [15:0]   rnd_ff, rnd_in;
   logic [31:0]   rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [31:0]   dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [71:0]   acc_ff, acc_in;
   logic [22:0]   z2_ff, z2_in;
   logic [19:0]   z3_ff, z3_in;
   logic [19:0]   z4_ff, z4_in;
   logic [19:0]   d6_ff, d6_in;
   logic [30:0]   p_ff, p_in;
   logic          dec_accept_ff, dec_accept_in;
   logic [1:0]    dec_kind_ff, dec_kind_in;

   // result register
   logic        out_accept_ff, out_accept_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [31:0] out_temp_ff, out_temp_in;
   logic        out_surface_ff, out_surface_in;
   logic        out_finished_ff, out_finished_in;
   logic [31:0] out_down_ff, out_down_in;
   logic [31:0] out_up_ff, out_up_in;

   // combinational helpers
   logic          positive;
   logic          finished;
   logic          sample_take;
   logic [32:0]   div_trial;
   logic [32:0]   div_diff;
   logic          div_ge;
   logic [47:0]   cool_prod;
   logic [15:0]   mean_slice;
   logic [39:0]   scale_prod;
   logic [71:0]   scale_term;
   logic [55:0]   scaled_temp;
   logic          x_big;
   logic [26:0]   z;
   logic [53:0]   z2_prod;
   logic [49:0]   z3_prod;
   logic [46:0]   z4_prod;
   logic [39:0]   d6_prod;
   logic [39:0]   d24_prod;
   logic [31:0]   poly_sum;
   logic [61:0]   sq_prod;
   logic [31:0]   sq_round;
   logic [16:0]   threshold;

   assign positive = (raw_ff != 32'd0) && !raw_ff[31];
   assign finished = CMP_W'(iteration_ff) >= CMP_W'(max_iterations_ff);
   assign sample_take = !start_set_ff && positive && (sample_count_ff < initial_samples_ff);

   // restoring divide step
   assign div_trial = {rem_ff, quo_ff[DW-1]};
   assign div_diff  = div_trial - {1'b0, dvs_ff};
   assign div_ge    = (div_trial >= {1'b0, dvs_ff});

   assign cool_prod = {16'd0, temperature_ff} * {32'd0, cooling_factor_ff};

   // mean times scale, one 16-bit slice per cycle
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    mean_slice = quo_ff[15:0];
         2'd1:    mean_slice = quo_ff[31:16];
         default: mean_slice = quo_ff[47:32];
      endcase
   end
   assign scale_prod = {24'd0, mean_slice} * {16'd0, start_temp_scale_ff};
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    scale_term = {32'd0, scale_prod};
         2'd1:    scale_term = {16'd0, scale_prod, 16'd0};
         default: scale_term = {scale_prod, 32'd0};
      endcase
   end
   assign scaled_temp = acc_ff[71:16];

   // exponential by series and repeated squaring
   assign x_big    = (quo_ff[DW-1:21] != '0) || (quo_ff[20:0] > aac_pkg::X_LIMIT);
   assign z        = {quo_ff[20:0], 6'd0};
   assign z2_prod  = {27'd0, z} * {27'd0, z};
   assign z3_prod  = {27'd0, z2_ff} * {23'd0, z};
   assign z4_prod  = {27'd0, z3_ff} * {20'd0, z};
   assign d6_prod  = {20'd0, z3_ff} * {20'd0, aac_pkg::DIV6_MUL};
   assign d24_prod = {20'd0, z4_ff} * {20'd0, aac_pkg::DIV6_MUL};
   assign poly_sum = aac_pkg::Q30_ONE - {5'd0, z} + {10'd0, z2_ff[22:1]}
                     - {12'd0, d6_ff} + {16'd0, d24_prod[39:24]};
   assign sq_prod  = {31'd0, p_ff} * {31'd0, p_ff};
   assign sq_round = 32'((sq_prod + 62'h2000_0000) >> 30);
   assign threshold = 17'(({1'b0, p_ff} + 32'h2000) >> 14);

   always_comb begin
      iteration_in    = iteration_ff;
      temperature_in  = temperature_ff;
      sample_count_in = sample_count_ff;
      sample_sum_in   = sample_sum_ff;
      start_set_in    = start_set_ff;
      downhill_in     = downhill_ff;
      uphill_in       = uphill_ff;
      raw_in          = raw_ff;
      rnd_in          = rnd_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      dvs_in          = dvs_ff;
      cnt_in          = cnt_ff;
      acc_in          = acc_ff;
      z2_in           = z2_ff;
      z3_in           = z3_ff;
      z4_in           = z4_ff;
      d6_in           = d6_ff;
      p_in            = p_ff;
      dec_accept_in   = dec_accept_ff;
      dec_kind_in     = dec_kind_ff;
      out_accept_in   = out_accept_ff;
      out_kind_in     = out_kind_ff;
      out_temp_in     = out_temp_ff;
      out_surface_in  = out_surface_ff;
      out_finished_in = out_finished_ff;
      out_down_in     = out_down_ff;
      out_up_in       = out_up_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      unique case (op)
         aac_pkg::OP_NONE: ;
         aac_pkg::OP_LOAD: begin
            raw_in = req_energy_change;
            rnd_in = req_random_uniform;
         end
         aac_pkg::OP_MOD_START: begin
            rem_in = '0;
            quo_in = DW'(iteration_ff);
            dvs_in = (chain_length_ff == 20'd0) ? 32'd1 : {12'd0, chain_length_ff};
            cnt_in = '0;
         end
         aac_pkg::OP_DIV_STEP: begin
            rem_in = div_ge ? div_diff[31:0] : div_trial[31:0];
            quo_in = {quo_ff[DW-2:0], div_ge};
            cnt_in = (cnt_ff == aac_pkg::DIV_LAST) ? '0 : cnt_ff + CW'(1);
         end
         aac_pkg::OP_COOL: begin
            if (rem_ff == 32'd0) temperature_in = cool_prod[47:16];
         end
         aac_pkg::OP_SAMPLE: begin
            if (sample_take) begin
               sample_sum_in   = sample_sum_ff + {16'd0, raw_ff};
               sample_count_in = sample_count_ff + 16'd1;
            end
         end
         aac_pkg::OP_MEAN_START: begin
            rem_in = '0;
            quo_in = sample_sum_ff;
            dvs_in = {16'd0, initial_samples_ff};
            cnt_in = '0;
            acc_in = '0;
         end
         aac_pkg::OP_SCALE_STEP: begin
            acc_in = acc_ff + scale_term;
            cnt_in = (cnt_ff == aac_pkg::SCALE_LAST) ? '0 : cnt_ff + CW'(1);
         end
         aac_pkg::OP_SET_TEMP: begin
            temperature_in = (scaled_temp[55:32] != '0) ? 32'hFFFF_FFFF
                                                         : scaled_temp[31:0];
            start_set_in   = 1'b1;
         end
         aac_pkg::OP_RATIO_START: begin
            rem_in = '0;
            quo_in = {raw_ff, 16'd0};
            dvs_in = temperature_ff;
            cnt_in = '0;
         end
         aac_pkg::OP_Z2: z2_in = z2_prod[52:30];
         aac_pkg::OP_Z3: z3_in = z3_prod[49:30];
         aac_pkg::OP_Z4: begin
            z4_in = {3'd0, z4_prod[46:30]};
            d6_in = {2'd0, d6_prod[39:aac_pkg::DIV6_SHIFT]};
         end
         aac_pkg::OP_POLY: begin
            p_in   = poly_sum[30:0];
            cnt_in = '0;
         end
         aac_pkg::OP_SQUARE: begin
            p_in   = sq_round[30:0];
            cnt_in = (cnt_ff == aac_pkg::SQUARE_LAST) ? '0 : cnt_ff + CW'(1);
         end
         aac_pkg::OP_DECIDE: begin
            dec_accept_in = 1'b0;
            dec_kind_in   = aac_pkg::KIND_REJECT;
            if (!positive) begin
               dec_accept_in = 1'b1;
               dec_kind_in   = aac_pkg::KIND_DOWNHILL;
               downhill_in   = downhill_ff + 32'd1;
            end else if ((temperature_ff != 32'd0) && !x_big &&
                         ({1'b0, rnd_ff} < threshold)) begin
               dec_accept_in = 1'b1;
               dec_kind_in   = aac_pkg::KIND_UPHILL;
               uphill_in     = uphill_ff + 32'd1;
            end
            iteration_in = iteration_ff + ITER_WIDTH'(1);
         end
         aac_pkg::OP_REJECT: begin
            dec_accept_in = 1'b0;
            dec_kind_in   = aac_pkg::KIND_REJECT;
         end
         aac_pkg::OP_OUTPUT: begin
            out_accept_in   = dec_accept_ff;
            out_kind_in     = dec_kind_ff;
            out_temp_in     = temperature_ff;
            out_surface_in  = CMP_W'(iteration_ff) >= CMP_W'(surface_start_ff);
            out_finished_in = finished;
            out_down_in     = downhill_ff;
            out_up_in       = uphill_ff;
            rsp_valid_in    = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iteration_ff    <= '0;
         temperature_ff  <= aac_pkg::TEMP_RESET;
         sample_count_ff <= '0;
         sample_sum_ff   <= '0;
         start_set_ff    <= 1'b0;
         downhill_ff     <= '0;
         uphill_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
         cnt_ff          <= '0;
      end else begin
         iteration_ff    <= iteration_in;
         temperature_ff  <= temperature_in;
         sample_count_ff <= sample_count_in;
         sample_sum_ff   <= sample_sum_in;
         start_set_ff    <= start_set_in;
         downhill_ff     <= downhill_in;
         uphill_ff       <= uphill_in;
         rsp_valid_ff    <= rsp_valid_in;
         cnt_ff          <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff          <= raw_in;
      rnd_ff          <= rnd_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      dvs_ff          <= dvs_in;
      acc_ff          <= acc_in;
      z2_ff           <= z2_in;
      z3_ff           <= z3_in;
      z4_ff           <= z4_in;
      d6_ff           <= d6_in;
      p_ff            <= p_in;
      dec_accept_ff   <= dec_accept_in;
      dec_kind_ff     <= dec_kind_in;
      out_accept_ff   <= out_accept_in;
      out_kind_ff     <= out_kind_in;
      out_temp_ff     <= out_temp_in;
      out_surface_ff  <= out_surface_in;
      out_finished_ff <= out_finished_in;
      out_down_ff     <= out_down_in;
      out_up_ff       <= out_up_in;
   end

   always_comb begin
      status.finished    = finished;
      status.positive    = positive;
      status.temp_zero   = (temperature_ff == 32'd0);
      status.sample_fill = sample_take && ((sample_count_ff + 16'd1) == initial_samples_ff);
      status.div_last    = (cnt_ff == aac_pkg::DIV_LAST);
      status.scale_last  = (cnt_ff == aac_pkg::SCALE_LAST);
      status.square_last = (cnt_ff == aac_pkg::SQUARE_LAST);
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accept         = out_accept_ff;
   assign rsp_accept_kind    = out_kind_ff;
   assign rsp_current_temp   = out_temp_ff;
   assign rsp_surface_phase  = out_surface_ff;
   assign rsp_finished       = out_finished_ff;
   assign rsp_downhill_total = out_down_ff;
   assign rsp_uphill_total   = out_up_ff;

endmodule

@@ design/annealing_acceptance_controller_top.sv @@
// ----------------------------------------------------------------------------
// annealing_acceptance_controller_top
// metropolis acceptance of proposed swaps with geometric cooling
// ----------------------------------------------------------------------------
// steps: an uphill request runs two 48-step passes of the shared restoring
//   divider (modulo, ratio), series and squaring; a downhill one or one at
//   zero temperature skips the ratio pass onward, the last start-temperature
//   sample adds a mean pass and scaling, a finished one goes to the result
// throughput: one request at a time; the next is taken once the result is
//   loaded, which waits while a stalled result holds the register
// reset: synchronous; registers, temperature (1000.0) and counters return to
//   their defaults, the result register comes up empty
// ----------------------------------------------------------------------------
module annealing_acceptance_controller_top #(
   parameter int ITER_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_energy_change,
   input  logic [15:0]        req_random_uniform,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_accept,
   output logic [1:0]         rsp_accept_kind,
   output logic [31:0]        rsp_current_temp,
   output logic               rsp_surface_phase,
   output logic               rsp_finished,
   output logic [31:0]        rsp_downhill_total,
   output logic [31:0]        rsp_uphill_total,
   // register writes
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   // command and status between sequencer and datapath
   aac_pkg::aac_op_type     op;
   aac_pkg::aac_status_type status;

   // sequencer: one state per datapath step, divider, scaling and squaring loops
   // repeat in place until the datapath flags the last step
   aac_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   // datapath: annealing state, divider, series evaluation, result register
   aac_datapath #(
      .ITER_WIDTH (ITER_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_energy_change  (req_energy_change),
      .req_random_uniform (req_random_uniform),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accept         (rsp_accept),
      .rsp_accept_kind    (rsp_accept_kind),
      .rsp_current_temp   (rsp_current_temp),
      .rsp_surface_phase  (rsp_surface_phase),
      .rsp_finished       (rsp_finished),
      .rsp_downhill_total (rsp_downhill_total),
      .rsp_uphill_total   (rsp_uphill_total)
   );

   // a taken request closes the request side until its result is loaded
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side open right after an accepted request");

   // accept flag and decision kind agree
   a_accept_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accept == (rsp_accept_kind != aac_pkg::KIND_REJECT)))
      else $error("accept flag disagrees with decision kind");

   // no undefined decision kind
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accept_kind <= aac_pkg::KIND_UPHILL))
      else $error("undefined decision kind");

   // a taken request does not load a result right away
   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result loaded while a request was just taken");

endmodule
